@@ rtl/pin_command_line_parser_core_macros.svh @@
// Assertion macros for the pin command line parser core.
// Taken in by the top level; no other dependencies.
`ifndef PIN_COMMAND_LINE_PARSER_CORE_MACROS_SVH
`define PIN_COMMAND_LINE_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PCLP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("pclp assertion failed");

// Next-cycle implication, checked out of reset.
`define PCLP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("pclp assertion failed");

`endif

@@ rtl/pclp_pkg.sv @@
// Shared types and codes of the pin command line parser.
// No dependencies; used by every module.
package pclp_pkg;

  localparam int FIFO_DEPTH = 2;

  localparam logic [7:0] CH_UM    = 8'h4D;
  localparam logic [7:0] CH_UG    = 8'h47;
  localparam logic [7:0] CH_US    = 8'h53;
  localparam logic [7:0] CH_UI    = 8'h49;
  localparam logic [7:0] CH_UO    = 8'h4F;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LI    = 8'h69;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_LT    = 8'h74;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D7    = 8'h37;

  localparam logic [1:0] CMD_MODE = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_GET  = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [2:0] VAL_INPUT  = 3'd2;
  localparam logic [2:0] VAL_OUTPUT = 3'd3;
  localparam logic [2:0] VAL_ANALOG = 3'd4;

  localparam logic [3:0] STS_OK       = 4'd0;
  localparam logic [3:0] STS_BAD_CMD  = 4'd1;
  localparam logic [3:0] STS_BAD_PORT = 4'd2;
  localparam logic [3:0] STS_BAD_PIN  = 4'd3;
  localparam logic [3:0] STS_BAD_VAL  = 4'd4;
  localparam logic [3:0] STS_WANT_N   = 4'd5;
  localparam logic [3:0] STS_WANT_T   = 4'd6;
  localparam logic [3:0] STS_WANT_D   = 4'd7;
  localparam logic [3:0] STS_WANT_E   = 4'd8;
  localparam logic [3:0] STS_OTHER    = 4'd9;

  typedef enum logic [3:0] {
    TK_RESTART,
    TK_NL,
    TK_CMD,
    TK_I,
    TK_N,
    TK_E,
    TK_O,
    TK_D,
    TK_T,
    TK_PORT,
    TK_DIGIT,
    TK_SPACE,
    TK_EQ,
    TK_MODEV,
    TK_OTHER
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [2:0] arg;
  } tok_t;

  typedef struct packed {
    logic valid;
    tok_t tok;
  } q_head_t;

endpackage

@@ rtl/pclp_if.sv @@
// Handshake channels of the pin command line parser.
// Depends on nothing; payload widths follow the port list.
interface pclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       restart;
  modport source (output valid, output ch, output restart, input ready);
  modport sink (input valid, input ch, input restart, output ready);
endinterface

interface pclp_out_if;
  logic       valid;
  logic       ready;
  logic       line_done;
  logic [3:0] status;
  logic [1:0] command;
  logic [2:0] port;
  logic [2:0] pin;
  logic [2:0] value;
  modport source (output valid, output line_done, output status, output command,
                  output port, output pin, output value, input ready);
  modport sink (input valid, input line_done, input status, input command,
                input port, input pin, input value, output ready);
endinterface

@@ rtl/pin_command_line_parser_core.sv @@
// Pin command line parser: one result word for every accepted character word.
// An accepted word is written into the token queue, then registered in the result register.
// Throughput: one word per cycle while the queue is not full; the line state machine takes a token on every pop.
// The token queue (FIFO_DEPTH words) and the result register absorb output stalls.
// Reset (rst_n low, synchronous) empties the queue and returns to the command state.
`include "pin_command_line_parser_core_macros.svh"

module pin_command_line_parser_core #(
  parameter int FIFO_DEPTH = pclp_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  pclp_in_if.sink     in_chan,
  pclp_out_if.source  out_chan
);

  logic              push;
  logic              pop;
  logic              q_full;
  pclp_pkg::tok_t    push_tok;
  pclp_pkg::q_head_t head;

  pclp_front u_front (
    .in_chan  (in_chan),
    .q_full   (q_full),
    .push     (push),
    .push_tok (push_tok)
  );

  pclp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head     (head),
    .full     (q_full)
  );

  pclp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

  `PCLP_ASSERT_NOW(a_idle_fields_zero, clk, rst_n,
    out_chan.valid && !out_chan.line_done,
    out_chan.status == 4'd0 && out_chan.command == 2'd0 && out_chan.port == 3'd0 &&
    out_chan.pin == 3'd0 && out_chan.value == 3'd0)
  `PCLP_ASSERT_NOW(a_error_fields_zero, clk, rst_n,
    out_chan.valid && out_chan.status != pclp_pkg::STS_OK,
    out_chan.line_done && out_chan.command == 2'd0 && out_chan.port == 3'd0 &&
    out_chan.pin == 3'd0 && out_chan.value == 3'd0)
  `PCLP_ASSERT_NEXT(a_pop_fills_output, clk, rst_n, pop, out_chan.valid)
  `PCLP_ASSERT_NEXT(a_accept_kept, clk, rst_n,
    in_chan.valid && in_chan.ready, head.valid || out_chan.valid)

endmodule

@@ rtl/pclp_front.sv @@
// Front end: classifies each incoming character into a token word.
// Depends on pclp_pkg and pclp_in_if.
module pclp_front (
  pclp_in_if.sink          in_chan,
  input  logic             q_full,
  output logic             push,
  output pclp_pkg::tok_t   push_tok
);

  logic [7:0] port_off;
  logic [7:0] pin_off;

  assign port_off = in_chan.ch - pclp_pkg::CH_UA;
  assign pin_off  = in_chan.ch - pclp_pkg::CH_D0;

  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;

  always_comb begin
    push_tok.kind = pclp_pkg::TK_OTHER;
    push_tok.arg  = 3'd0;
    if (in_chan.restart) begin
      push_tok.kind = pclp_pkg::TK_RESTART;
    end else begin
      case (in_chan.ch)
        pclp_pkg::CH_NL: push_tok.kind = pclp_pkg::TK_NL;
        pclp_pkg::CH_UM: begin
          push_tok.kind = pclp_pkg::TK_CMD;
          push_tok.arg  = {1'b0, pclp_pkg::CMD_MODE};
        end
        pclp_pkg::CH_US: begin
          push_tok.kind = pclp_pkg::TK_CMD;
          push_tok.arg  = {1'b0, pclp_pkg::CMD_SET};
        end
        pclp_pkg::CH_UG: begin
          push_tok.kind = pclp_pkg::TK_CMD;
          push_tok.arg  = {1'b0, pclp_pkg::CMD_GET};
        end
        pclp_pkg::CH_UI: begin
          push_tok.kind = pclp_pkg::TK_MODEV;
          push_tok.arg  = pclp_pkg::VAL_INPUT;
        end
        pclp_pkg::CH_UO: begin
          push_tok.kind = pclp_pkg::TK_MODEV;
          push_tok.arg  = pclp_pkg::VAL_OUTPUT;
        end
        pclp_pkg::CH_LI:    push_tok.kind = pclp_pkg::TK_I;
        pclp_pkg::CH_LN:    push_tok.kind = pclp_pkg::TK_N;
        pclp_pkg::CH_LE:    push_tok.kind = pclp_pkg::TK_E;
        pclp_pkg::CH_LO:    push_tok.kind = pclp_pkg::TK_O;
        pclp_pkg::CH_LD:    push_tok.kind = pclp_pkg::TK_D;
        pclp_pkg::CH_LT:    push_tok.kind = pclp_pkg::TK_T;
        pclp_pkg::CH_SPACE: push_tok.kind = pclp_pkg::TK_SPACE;
        pclp_pkg::CH_EQ:    push_tok.kind = pclp_pkg::TK_EQ;
        default: begin
          if (in_chan.ch inside {[pclp_pkg::CH_UA:pclp_pkg::CH_UF]}) begin
            push_tok.kind = pclp_pkg::TK_PORT;
            push_tok.arg  = port_off[2:0];
          end else if (in_chan.ch inside {[pclp_pkg::CH_D0:pclp_pkg::CH_D7]}) begin
            push_tok.kind = pclp_pkg::TK_DIGIT;
            push_tok.arg  = pin_off[2:0];
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/pclp_fifo.sv @@
// Token queue between the classifying front end and the parsing back end.
// Depends on pclp_pkg.
module pclp_fifo #(
  parameter int DEPTH = pclp_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pclp_pkg::tok_t     push_tok,
  input  logic               pop,
  output pclp_pkg::q_head_t  head,
  output logic               full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pclp_pkg::tok_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.tok   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = CNT_W'(count_r + CNT_W'(push) - CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_tok;
    end
  end

endmodule

@@ rtl/pclp_back.sv @@
// Back end: runs the line state machine on token words and registers results.
// Depends on pclp_pkg and pclp_out_if.
module pclp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pclp_pkg::q_head_t  head,
  output logic               pop,
  pclp_out_if.source         out_chan
);

  localparam logic [3:0] S_CMD   = 4'd0;
  localparam logic [3:0] S_N     = 4'd1;
  localparam logic [3:0] S_T     = 4'd2;
  localparam logic [3:0] S_D     = 4'd3;
  localparam logic [3:0] S_E     = 4'd4;
  localparam logic [3:0] S_PORT  = 4'd5;
  localparam logic [3:0] S_PIN   = 4'd6;
  localparam logic [3:0] S_VALUE = 4'd7;
  localparam logic [3:0] S_EOL   = 4'd8;
  localparam logic [3:0] S_ERR   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic [2:0] port_r, port_nxt;
  logic [2:0] pin_r, pin_nxt;
  logic [2:0] val_r, val_nxt;

  logic       done;
  logic [3:0] sts;

  logic       out_valid_r;
  logic       line_done_r;
  logic [3:0] status_r;
  logic [1:0] command_r;
  logic [2:0] oport_r;
  logic [2:0] opin_r;
  logic [2:0] ovalue_r;

  pclp_pkg::tok_kind_t kind;
  logic [2:0]          arg;

  assign kind = head.tok.kind;
  assign arg  = head.tok.arg;
  assign pop  = head.valid && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    port_nxt  = port_r;
    pin_nxt   = pin_r;
    val_nxt   = val_r;
    done      = 1'b0;
    sts       = pclp_pkg::STS_OK;
    if (kind == pclp_pkg::TK_RESTART) begin
      state_nxt = S_CMD;
      cmd_nxt   = pclp_pkg::CMD_NONE;
      port_nxt  = 3'd0;
      pin_nxt   = 3'd0;
      val_nxt   = 3'd0;
    end else begin
      case (state_r)
        S_CMD: begin
          if (kind == pclp_pkg::TK_CMD) begin
            cmd_nxt   = arg[1:0];
            state_nxt = S_PORT;
          end else if (kind == pclp_pkg::TK_I) begin
            state_nxt = S_N;
          end else if (kind == pclp_pkg::TK_NL) begin
            done = 1'b1;
            sts  = pclp_pkg::STS_BAD_CMD;
          end else begin
            state_nxt = S_ERR;
          end
        end
        S_PORT: begin
          if (kind == pclp_pkg::TK_PORT) begin
            port_nxt  = arg;
            state_nxt = S_PIN;
          end else if (kind == pclp_pkg::TK_E) begin
            state_nxt = S_T;
          end else if (kind == pclp_pkg::TK_O) begin
            state_nxt = S_D;
          end else if (kind == pclp_pkg::TK_NL) begin
            done = 1'b1;
            sts  = pclp_pkg::STS_BAD_PORT;
          end else begin
            state_nxt = S_ERR;
          end
        end
        S_PIN: begin
          if (kind == pclp_pkg::TK_DIGIT) begin
            pin_nxt   = arg;
            state_nxt = (cmd_r == pclp_pkg::CMD_GET) ? S_EOL : S_VALUE;
          end else if (kind == pclp_pkg::TK_NL) begin
            done = 1'b1;
            sts  = pclp_pkg::STS_BAD_PIN;
          end else begin
            state_nxt = S_ERR;
          end
        end
        S_VALUE: begin
          if (kind == pclp_pkg::TK_SPACE || kind == pclp_pkg::TK_EQ) begin
            state_nxt = S_VALUE;
          end else if (kind == pclp_pkg::TK_DIGIT && arg[2:1] == 2'd0) begin
            if (cmd_r != pclp_pkg::CMD_SET) begin
              state_nxt = S_ERR;
            end else begin
              val_nxt   = arg;
              state_nxt = S_EOL;
            end
          end else if (kind == pclp_pkg::TK_MODEV ||
                       (kind == pclp_pkg::TK_PORT && arg == 3'd0)) begin
            if (cmd_r != pclp_pkg::CMD_MODE) begin
              state_nxt = S_ERR;
            end else begin
              val_nxt   = (kind == pclp_pkg::TK_MODEV) ? arg : pclp_pkg::VAL_ANALOG;
              state_nxt = S_EOL;
            end
          end else if (kind == pclp_pkg::TK_NL) begin
            done = 1'b1;
            sts  = pclp_pkg::STS_BAD_VAL;
          end else begin
            state_nxt = S_ERR;
          end
        end
        S_EOL: begin
          if (kind == pclp_pkg::TK_SPACE) begin
            state_nxt = S_EOL;
          end else if (kind == pclp_pkg::TK_NL) begin
            done = 1'b1;
            sts  = pclp_pkg::STS_OK;
          end else begin
            state_nxt = S_ERR;
          end
        end
        S_N: begin
          if (kind == pclp_pkg::TK_N) begin
            state_nxt = S_CMD;
          end else if (kind == pclp_pkg::TK_NL) begin
            done = 1'b1;
            sts  = pclp_pkg::STS_WANT_N;
          end else begin
            state_nxt = S_ERR;
          end
        end
        S_T: begin
          if (kind == pclp_pkg::TK_T) begin
            state_nxt = S_PORT;
          end else if (kind == pclp_pkg::TK_NL) begin
            done = 1'b1;
            sts  = pclp_pkg::STS_WANT_T;
          end else begin
            state_nxt = S_ERR;
          end
        end
        S_D: begin
          if (kind == pclp_pkg::TK_D) begin
            state_nxt = S_E;
          end else if (kind == pclp_pkg::TK_NL) begin
            done = 1'b1;
            sts  = pclp_pkg::STS_WANT_D;
          end else begin
            state_nxt = S_ERR;
          end
        end
        S_E: begin
          if (kind == pclp_pkg::TK_E) begin
            state_nxt = S_PORT;
          end else if (kind == pclp_pkg::TK_NL) begin
            done = 1'b1;
            sts  = pclp_pkg::STS_WANT_E;
          end else begin
            state_nxt = S_ERR;
          end
        end
        default: begin
          state_nxt = S_ERR;
          if (kind == pclp_pkg::TK_NL) begin
            done = 1'b1;
            sts  = pclp_pkg::STS_OTHER;
          end
        end
      endcase
      // every line end drops back to the start state
      if (done) begin
        state_nxt = S_CMD;
        cmd_nxt   = pclp_pkg::CMD_NONE;
        port_nxt  = 3'd0;
        pin_nxt   = 3'd0;
        val_nxt   = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CMD;
      cmd_r       <= pclp_pkg::CMD_NONE;
      port_r      <= 3'd0;
      pin_r       <= 3'd0;
      val_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        state_r     <= state_nxt;
        cmd_r       <= cmd_nxt;
        port_r      <= port_nxt;
        pin_r       <= pin_nxt;
        val_r       <= val_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      line_done_r <= done;
      status_r    <= sts;
      if (done && sts == pclp_pkg::STS_OK) begin
        command_r <= cmd_r;
        oport_r   <= port_r;
        opin_r    <= pin_r;
        ovalue_r  <= (cmd_r == pclp_pkg::CMD_GET) ? 3'd0 : val_r;
      end else begin
        command_r <= 2'd0;
        oport_r   <= 3'd0;
        opin_r    <= 3'd0;
        ovalue_r  <= 3'd0;
      end
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.line_done = line_done_r;
  assign out_chan.status    = status_r;
  assign out_chan.command   = command_r;
  assign out_chan.port      = oport_r;
  assign out_chan.pin       = opin_r;
  assign out_chan.value     = ovalue_r;

endmodule
